// ===== rtl/core/unsigned_divider_with_remainder_macros.svh =====
// Assertion macros for the unsigned divider.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef UNSIGNED_DIVIDER_WITH_REMAINDER_MACROS_SVH
`define UNSIGNED_DIVIDER_WITH_REMAINDER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define UDIV_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udiv assertion failed");
// Next-cycle implication
`define UDIV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udiv assertion failed");
`else
`define UDIV_ASSERT_NOW(label, ante, cons)
`define UDIV_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/udiv_pkg.sv =====
// Shared types and constants for the unsigned divider.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package udiv_pkg;

    // Default operand width
    localparam int DATA_WIDTH_DEF = 32;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } udiv_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture operands, clear partial remainder
        logic step;       // one shift-subtract iteration
        logic emit;       // load the output register
        logic emit_held;  // emit from the held registers, not the step result
    } udiv_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last;       // current step is the final one
    } udiv_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/unsigned_divider_with_remainder.sv =====
// Unsigned divider with remainder, radix-2 restoring, one quotient bit per cycle.
// The single shift-subtract unit takes no new word until the current one is through.
// The next word is accepted while a finished result waits in the output register.
// A zero divisor flags tuser and gives all-ones quotient, remainder = dividend.
// Reset (rst_n, async, active low) clears control state only; no clearing pass.
`default_nettype none

`include "unsigned_divider_with_remainder_macros.svh"

module unsigned_divider_with_remainder #(
    parameter int DATA_WIDTH = udiv_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // numerator, denominator
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // quotient, remainder
    output logic      [((2*DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    // zero_divisor
    output logic                                        m_axis_tuser
);
    import udiv_pkg::*;

    localparam int TDATA_W = ((2*DATA_WIDTH+7)/8)*8;

    udiv_cmd_t             cmd;
    udiv_stat_t            stat;
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;

    udiv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    udiv_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .numerator    (s_axis_tdata[DATA_WIDTH-1:0]),
        .denominator  (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .quotient     (quotient),
        .remainder    (remainder),
        .zero_divisor (m_axis_tuser)
    );

    // Pack output word, zero padded to whole bytes
    assign m_axis_tdata = TDATA_W'({remainder, quotient});

    // Busy for the whole iteration once a word is taken
    `UDIV_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Zero divisor result always carries the all-ones quotient
    `UDIV_ASSERT_NOW(a_zero_div_quotient, m_axis_tvalid && m_axis_tuser, quotient == '1)
    // Iteration only runs while the input side is closed
    `UDIV_ASSERT_NOW(a_step_only_running, cmd.step, !s_axis_tready)

endmodule

`default_nettype wire

// ===== rtl/core/udiv_dp.sv =====
// Datapath of the unsigned divider: operand registers, shift-subtract
// iteration, step counter and output register. Depends on udiv_pkg.
`default_nettype none

module udiv_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire udiv_pkg::udiv_cmd_t   cmd,
    output udiv_pkg::udiv_stat_t       stat,
    input  wire logic [DATA_WIDTH-1:0] numerator,
    input  wire logic [DATA_WIDTH-1:0] denominator,
    output logic      [DATA_WIDTH-1:0] quotient,
    output logic      [DATA_WIDTH-1:0] remainder,
    output logic                       zero_divisor
);
    import udiv_pkg::*;

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    logic [DATA_WIDTH-1:0] div_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic                  zero_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DATA_WIDTH-1:0] q_out_reg;
    logic [DATA_WIDTH-1:0] r_out_reg;
    logic                  z_out_reg;

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;
    logic [DATA_WIDTH-1:0] rem_step;
    logic [DATA_WIDTH-1:0] quo_step;

    // One restoring step: bring down the next dividend bit, try the subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DATA_WIDTH-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = ~diff[DATA_WIDTH];
        rem_step = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        quo_step = {quo_reg[DATA_WIDTH-2:0], fits};
    end

    assign stat.last = (cnt_reg == '0);

    // Working registers; a zero divisor falls out naturally as all-ones
    // quotient with the dividend left as remainder
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg  <= numerator;
            rem_reg  <= '0;
            div_reg  <= denominator;
            zero_reg <= (denominator == '0);
        end
        else if (cmd.step)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= CNT_W'(DATA_WIDTH - 1);
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            q_out_reg <= cmd.emit_held ? quo_reg : quo_step;
            r_out_reg <= cmd.emit_held ? rem_reg : rem_step;
            z_out_reg <= zero_reg;
        end
    end

    assign quotient     = q_out_reg;
    assign remainder    = r_out_reg;
    assign zero_divisor = z_out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/udiv_ctrl.sv =====
// Controller of the unsigned divider: sequences load, iteration and
// output hand-off, and owns both handshakes. Depends on udiv_pkg.
`default_nettype none

module udiv_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire udiv_pkg::udiv_stat_t stat,
    output udiv_pkg::udiv_cmd_t       cmd
);
    import udiv_pkg::*;

    udiv_state_t state_reg;
    udiv_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    // Output register can take a word when empty or being drained
    assign out_free = ~out_valid_reg | out_ready;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (stat.last)
                begin
                    if (out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.emit | (out_valid_reg & ~out_ready);
    end

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for unsigned_divider_with_remainder: a table of directed words,
// then constrained-by-hand random words with random source and sink throttling.
// Depends on udiv_pkg and the divider RTL; no files, arguments or external code.
`default_nettype none

module tb;

    import udiv_pkg::*;

    localparam int DW         = DATA_WIDTH_DEF;
    localparam int TDW        = ((2*DW+7)/8)*8;
    localparam int RAND_WORDS = 450;
    localparam int IDLE_LIMIT = 4000;   // cycles with no handshake on either side
    localparam int MAX_REPORT = 10;

    // One divider result, checked field by field
    typedef struct packed {
        logic          zero_div;
        logic [DW-1:0] rem;
        logic [DW-1:0] quot;
    } div_result_t;

    // Directed row: operands, plus the result where it is obvious by inspection
    typedef struct {
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        bit            typed;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
        logic          zero_div;
    } div_row_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata = '0;      // numerator, denominator
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [TDW-1:0] m_axis_tdata;           // quotient, remainder
    logic           m_axis_tuser;           // zero_divisor

    div_result_t    quot_rem_q[$];          // results still owed by the divider
    bit             src_throttle = 1'b1;
    bit             sink_throttle = 1'b1;
    int unsigned    words_sent = 0;
    int unsigned    results_checked = 0;
    int unsigned    zero_div_seen = 0;
    int unsigned    mismatches = 0;
    int unsigned    idle_cycles = 0;

    unsigned_divider_with_remainder #(
        .DATA_WIDTH (DW)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Expected quotient and remainder; all ones and the dividend on a zero divisor
    function automatic div_result_t divide_expect(logic [DW-1:0] num, logic [DW-1:0] den);
        div_result_t res;
        if (den == '0)
        begin
            res.quot     = '1;
            res.rem      = num;
            res.zero_div = 1'b1;
        end
        else
        begin
            res.quot     = num / den;
            res.rem      = num % den;
            res.zero_div = 1'b0;
        end
        return res;
    endfunction

    // Random operands, biased towards the interesting divisor ranges
    function automatic logic [2*DW-1:0] pick_operands();
        logic [DW-1:0] num;
        logic [DW-1:0] den;
        num = $urandom;
        den = $urandom;
        case ($urandom_range(0, 9))
            0: den = '0;
            1: den = $urandom_range(1, 255);
            2: den = num + $urandom_range(1, 1000);                  // usually above num
            3: den = {1'b1, den[DW-2:0]};                           // top bit set
            4: den = num;
            5: den = 1 << $urandom_range(0, DW-1);
            6: num = $urandom_range(0, 65535);
            7:
            begin
                den = $urandom_range(1, 65535);
                num = den * $urandom_range(0, 65535);               // exact multiples
            end
            default: ;
        endcase
        return {den, num};
    endfunction

    // Present one word; the expectation is queued at the accepting edge
    task automatic send_word(logic [DW-1:0] num, logic [DW-1:0] den, div_result_t res);
        int gap;
        gap = 0;
        while (src_throttle && $urandom_range(0, 99) < 7)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDW'({den, num});
        do
            @(posedge clk);
        while (!s_axis_tready);
        quot_rem_q.push_back(res);
        words_sent++;
    endtask

    // Hold the source back until every owed result has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (quot_rem_q.size() != 0)
            @(posedge clk);
    endtask

    // Sink readiness
    always @(posedge clk)
    begin
        m_axis_tready <= !(sink_throttle && $urandom_range(0, 99) < 7);
    end

    // Result checker
    always @(posedge clk)
    begin
        div_result_t want;
        div_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.quot     = m_axis_tdata[DW-1:0];
            got.rem      = m_axis_tdata[2*DW-1:DW];
            got.zero_div = m_axis_tuser;
            if (quot_rem_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("unexpected result: quot %h rem %h zdiv %b",
                             got.quot, got.rem, got.zero_div);
            end
            else
            begin
                want = quot_rem_q.pop_front();
                results_checked++;
                if (got.zero_div)
                    zero_div_seen++;
                if (got.quot !== want.quot || got.rem !== want.rem
                    || got.zero_div !== want.zero_div)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("result %0d mismatch: quot %h/%h rem %h/%h zdiv %b/%b (exp/act)",
                                 results_checked, want.quot, got.quot, want.rem, got.rem,
                                 want.zero_div, got.zero_div);
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("unsigned_divider_with_remainder regression: fail");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        div_row_t         rows[$];
        div_result_t      res;
        logic [2*DW-1:0]  ops;
        int               n;

        // zero divisor, extremes, divisor above dividend, top-bit divisors
        rows = '{
            '{32'h0000_0000, 32'h0000_0000, 1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
            '{32'hFFFF_FFFF, 32'h0000_0000, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
            '{32'h1234_5678, 32'h0000_0000, 1, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1},
            '{32'h0000_0000, 32'h0000_0001, 1, 32'h0000_0000, 32'h0000_0000, 1'b0},
            '{32'hFFFF_FFFF, 32'h0000_0001, 1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0001, 32'h0000_0000, 1'b0},
            '{32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h0000_0000, 32'h0000_0000, 1'b0},
            '{32'h0000_0007, 32'h0000_0008, 1, 32'h0000_0000, 32'h0000_0007, 1'b0},
            '{32'h8000_0000, 32'h8000_0000, 1, 32'h0000_0001, 32'h0000_0000, 1'b0},
            '{32'hFFFF_FFFF, 32'h8000_0000, 1, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0},
            '{32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0},
            '{32'hFFFF_FFFF, 32'h0000_0002, 1, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0},
            '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0},
            '{32'h0000_0001, 32'hFFFF_FFFF, 1, 32'h0000_0000, 32'h0000_0001, 1'b0},
            '{32'hAAAA_AAAA, 32'h5555_5555, 1, 32'h0000_0002, 32'h0000_0000, 1'b0},
            '{32'h5555_5555, 32'hAAAA_AAAA, 0, '0, '0, 1'b0},
            '{32'h0000_0100, 32'h0000_0007, 0, '0, '0, 1'b0},
            '{32'h8000_0000, 32'h0000_0003, 0, '0, '0, 1'b0},
            '{32'hDEAD_BEEF, 32'h0000_1234, 0, '0, '0, 1'b0},
            '{32'hC000_0001, 32'hA000_0003, 0, '0, '0, 1'b0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                res.quot     = rows[i].quot;
                res.rem      = rows[i].rem;
                res.zero_div = rows[i].zero_div;
            end
            else
                res = divide_expect(rows[i].num, rows[i].den);
            send_word(rows[i].num, rows[i].den, res);
        end
        drain_results();

        // Random words; a middle stretch runs with no throttling on either side
        for (n = 0; n < RAND_WORDS; n++)
        begin
            src_throttle  = !(n >= 150 && n < 280);
            sink_throttle = src_throttle;
            if (n == 300)
                drain_results();
            ops = pick_operands();
            send_word(ops[DW-1:0], ops[2*DW-1:DW], divide_expect(ops[DW-1:0], ops[2*DW-1:DW]));
        end
        s_axis_tvalid <= 1'b0;

        // Let the last results out, then keep the clock running so that any stray extra result is caught
        while (quot_rem_q.size() != 0)
            @(posedge clk);
        repeat (DW + 8) @(posedge clk);

        $display("sent %0d words (%0d directed), checked %0d results, %0d with zero divisor",
                 words_sent, rows.size(), results_checked, zero_div_seen);
        $display("mismatches: %0d, results still owed: %0d", mismatches, quot_rem_q.size());
        if (mismatches == 0 && quot_rem_q.size() == 0)
            $display("unsigned_divider_with_remainder regression: pass");
        else
            $display("unsigned_divider_with_remainder regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/udiv_pkg.sv
rtl/core/udiv_dp.sv
rtl/core/udiv_ctrl.sv
rtl/core/unsigned_divider_with_remainder.sv
tb/tb.sv
